@@ rtl/core/bdpc_pkg.sv @@
// shared types and codes for the button debounce press classifier
package bdpc_pkg;

    localparam int TIME_W = 32;
    localparam int CODE_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b1;

    localparam logic [TIME_W-1:0] LONG_PRESS_RESET = 32'd1000;
    localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd30;

    localparam logic [CODE_W-1:0] EV_NONE = 2'd0;
    localparam logic [CODE_W-1:0] EV_SHORT = 2'd1;
    localparam logic [CODE_W-1:0] EV_LONG = 2'd2;

    localparam logic [CODE_W-1:0] NO_EDGE = 2'd0;
    localparam logic [CODE_W-1:0] EDGE_PRESS = 2'd1;
    localparam logic [CODE_W-1:0] EDGE_RELEASE = 2'd2;

    typedef struct packed {
        logic              raw_level;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic [CODE_W-1:0] press_event;
        logic [CODE_W-1:0] level_edge;
        logic              is_pressed;
        logic [TIME_W-1:0] press_duration_ms;
    } result_t;

endpackage

@@ rtl/core/bdpc_if.sv @@
// valid/ready channel interfaces for samples and results
interface bdpc_sample_if;
    logic                         valid;
    logic                         ready;
    logic                         raw_level;
    logic [bdpc_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, output raw_level, output now_ms, input ready);
    modport sink (input valid, input raw_level, input now_ms, output ready);
endinterface

interface bdpc_result_if;
    logic                         valid;
    logic                         ready;
    logic [bdpc_pkg::CODE_W-1:0]  press_event;
    logic [bdpc_pkg::CODE_W-1:0]  level_edge;
    logic                         is_pressed;
    logic [bdpc_pkg::TIME_W-1:0]  press_duration_ms;

    modport source (
        output valid, output press_event, output level_edge,
        output is_pressed, output press_duration_ms, input ready
    );
    modport sink (
        input valid, input press_event, input level_edge,
        input is_pressed, input press_duration_ms, output ready
    );
endinterface

@@ rtl/core/bdpc_in_stage.sv @@
// input register: holds one accepted sample until the classifier takes it
module bdpc_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    bdpc_sample_if.sink         sample,
    input  logic                advance,
    output logic                stage_valid,
    output bdpc_pkg::sample_t   stage_item
);

    logic              valid_reg;
    logic              valid_next;
    bdpc_pkg::sample_t item_reg;
    logic              take;

    assign sample.ready = !valid_reg || advance;
    assign take = sample.valid && sample.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.raw_level <= sample.raw_level;
            item_reg.now_ms <= sample.now_ms;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item = item_reg;

endmodule

@@ rtl/core/bdpc_classify.sv @@
// debounce and press classification state with its next-state logic
module bdpc_classify (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               fire,
    input  bdpc_pkg::sample_t                  item,
    output bdpc_pkg::result_t                  result
);

    logic [bdpc_pkg::TIME_W-1:0] long_press_reg;
    logic [bdpc_pkg::TIME_W-1:0] debounce_reg;

    logic                        last_raw_reg, last_raw_next;
    logic [bdpc_pkg::TIME_W-1:0] change_time_reg, change_time_next;
    logic                        stable_reg, stable_next;
    logic                        armed_reg, armed_next;
    logic                        long_sent_reg, long_sent_next;
    logic [bdpc_pkg::TIME_W-1:0] press_start_reg, press_start_next;
    logic [bdpc_pkg::TIME_W-1:0] release_dur_reg, release_dur_next;

    logic [bdpc_pkg::TIME_W-1:0] since_change;
    logic [bdpc_pkg::TIME_W-1:0] held_old;
    logic [bdpc_pkg::TIME_W-1:0] held_new;
    logic [bdpc_pkg::CODE_W-1:0] event_code;
    logic [bdpc_pkg::CODE_W-1:0] edge_code;

    always_comb
    begin
        last_raw_next = last_raw_reg;
        change_time_next = change_time_reg;
        if (item.raw_level != last_raw_reg)
        begin
            last_raw_next = item.raw_level;
            change_time_next = item.now_ms;
        end

        since_change = item.now_ms - change_time_next;
        stable_next = (since_change >= debounce_reg) ? item.raw_level : stable_reg;

        armed_next = armed_reg;
        long_sent_next = long_sent_reg;
        press_start_next = press_start_reg;
        release_dur_next = release_dur_reg;
        event_code = bdpc_pkg::EV_NONE;
        edge_code = bdpc_pkg::NO_EDGE;
        held_old = item.now_ms - press_start_reg;

        if (stable_next != stable_reg)
        begin
            if (!stable_next)
            begin
                edge_code = bdpc_pkg::EDGE_PRESS;
                armed_next = 1'b1;
                long_sent_next = 1'b0;
                press_start_next = item.now_ms;
            end
            else
            begin
                edge_code = bdpc_pkg::EDGE_RELEASE;
                if (armed_reg)
                begin
                    release_dur_next = held_old;
                    if (!long_sent_reg && (held_old < long_press_reg))
                    begin
                        event_code = bdpc_pkg::EV_SHORT;
                    end
                    armed_next = 1'b0;
                    long_sent_next = 1'b0;
                end
                else
                begin
                    release_dur_next = '0;
                end
            end
        end

        // hold time measured from the start recorded this step
        held_new = (edge_code == bdpc_pkg::EDGE_PRESS) ? '0 : held_old;

        if (!stable_next && armed_next && !long_sent_next && (held_new >= long_press_reg))
        begin
            event_code = bdpc_pkg::EV_LONG;
            long_sent_next = 1'b1;
        end

        result.press_event = event_code;
        result.level_edge = edge_code;
        result.is_pressed = !stable_next;
        result.press_duration_ms = !stable_next ? held_new : release_dur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= bdpc_pkg::LONG_PRESS_RESET;
            debounce_reg <= bdpc_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdpc_pkg::REG_LONG_PRESS: long_press_reg <= cfg_data;
                bdpc_pkg::REG_DEBOUNCE:   debounce_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg <= 1'b1;
            change_time_reg <= '0;
            stable_reg <= 1'b1;
            armed_reg <= 1'b0;
            long_sent_reg <= 1'b0;
            press_start_reg <= '0;
            release_dur_reg <= '0;
        end
        else if (fire)
        begin
            last_raw_reg <= last_raw_next;
            change_time_reg <= change_time_next;
            stable_reg <= stable_next;
            armed_reg <= armed_next;
            long_sent_reg <= long_sent_next;
            press_start_reg <= press_start_next;
            release_dur_reg <= release_dur_next;
        end
    end

endmodule

@@ rtl/core/button_debounce_press_classifier_unit.sv @@
// top level: input register, classifier state and result register
//
//  channel  | direction | handshake      | payload
//  sample   | in        | valid / ready  | raw_level, now_ms
//  result   | out       | valid / ready  | press_event, level_edge, is_pressed, press_duration_ms
//  cfg      | in        | cfg_we         | cfg_index, cfg_data
//
// one sample per cycle sustained while result is ready; a transferred sample reaches the result port
// through the input register, then the result register, with the classifier logic between them
// rst_n clears both stage valids, the debounce state and the config registers to defaults
// a stalled result holds the result register, and the input register fills behind it
module button_debounce_press_classifier_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    bdpc_sample_if.sink                      sample,
    bdpc_result_if.source                    result,
    input  logic                             cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic              stage_valid;
    bdpc_pkg::sample_t stage_item;
    logic              advance;
    logic              fire;
    bdpc_pkg::result_t next_result;

    logic              res_valid_reg;
    logic              res_valid_next;
    bdpc_pkg::result_t res_reg;

    assign advance = !res_valid_reg || result.ready;
    assign fire = stage_valid && advance;

    bdpc_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    bdpc_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (stage_item),
        .result    (next_result)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= next_result;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.press_event = res_reg.press_event;
    assign result.level_edge = res_reg.level_edge;
    assign result.is_pressed = res_reg.is_pressed;
    assign result.press_duration_ms = res_reg.press_duration_ms;

endmodule

@@ tb/tb.sv @@
// testbench for the button debounce press classifier: random presses checked against a predictor
`timescale 1ns / 1ps

module tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bdpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    bdpc_sample_if sample_ch ();
    bdpc_result_if result_ch ();

    button_debounce_press_classifier_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // predictor copy of the registers and the debounce state
    logic [bdpc_pkg::TIME_W-1:0] long_cfg_ms;
    logic [bdpc_pkg::TIME_W-1:0] debounce_cfg_ms;
    logic                        line_last;
    logic [bdpc_pkg::TIME_W-1:0] line_change_ms;
    logic                        line_stable;
    logic                        press_armed_q;
    logic                        long_fired;
    logic [bdpc_pkg::TIME_W-1:0] press_start_ms;
    logic [bdpc_pkg::TIME_W-1:0] last_hold_ms;

    bdpc_pkg::sample_t queued_samples[$];
    bdpc_pkg::result_t due_reports[$];

    logic [bdpc_pkg::TIME_W-1:0] stim_ms = '0;
    int stim_count = 0;
    int samples_sent = 0;
    int reports_checked = 0;
    int mismatch_count = 0;
    int settings_used = 1;
    int press_edges = 0;
    int release_edges = 0;
    int short_events = 0;
    int long_events = 0;

    int sample_gap = 0;
    int result_stall = 0;
    bit sample_burst = 1'b0;
    bit result_burst = 1'b0;

    task automatic classify_sample(input logic raw, input logic [bdpc_pkg::TIME_W-1:0] now,
                                   output bdpc_pkg::result_t res);
        logic                        was_stable;
        logic [bdpc_pkg::TIME_W-1:0] since_change;
        logic [bdpc_pkg::TIME_W-1:0] held;
        res = '0;
        res.press_event = bdpc_pkg::EV_NONE;
        res.level_edge = bdpc_pkg::NO_EDGE;
        was_stable = line_stable;
        if (raw != line_last)
        begin
            line_last = raw;
            line_change_ms = now;
        end
        since_change = now - line_change_ms;
        if (since_change >= debounce_cfg_ms)
            line_stable = raw;
        if (line_stable != was_stable)
        begin
            if (!line_stable)
            begin
                res.level_edge = bdpc_pkg::EDGE_PRESS;
                press_armed_q = 1'b1;
                long_fired = 1'b0;
                press_start_ms = now;
            end
            else
            begin
                res.level_edge = bdpc_pkg::EDGE_RELEASE;
                if (press_armed_q)
                begin
                    held = now - press_start_ms;
                    last_hold_ms = held;
                    if (!long_fired && held < long_cfg_ms)
                        res.press_event = bdpc_pkg::EV_SHORT;
                    press_armed_q = 1'b0;
                    long_fired = 1'b0;
                end
                else
                    last_hold_ms = '0;
            end
        end
        held = now - press_start_ms;
        // long fires once while held, even on the press step itself
        if (!line_stable && press_armed_q && !long_fired && held >= long_cfg_ms)
        begin
            res.press_event = bdpc_pkg::EV_LONG;
            long_fired = 1'b1;
        end
        res.is_pressed = !line_stable;
        res.press_duration_ms = line_stable ? last_hold_ms : held;
    endtask

    function automatic int pick_gap(input bit burst);
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        bdpc_pkg::result_t predicted;
        bdpc_pkg::sample_t next_sample;
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            sample_gap = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                classify_sample(sample_ch.raw_level, sample_ch.now_ms, predicted);
                due_reports.push_back(predicted);
                samples_sent++;
                if (predicted.level_edge == bdpc_pkg::EDGE_PRESS)
                    press_edges++;
                if (predicted.level_edge == bdpc_pkg::EDGE_RELEASE)
                    release_edges++;
                if (predicted.press_event == bdpc_pkg::EV_SHORT)
                    short_events++;
                if (predicted.press_event == bdpc_pkg::EV_LONG)
                    long_events++;
                if ($urandom_range(0, 47) == 0)
                    sample_burst = ~sample_burst;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (sample_gap > 0)
                begin
                    sample_gap--;
                    sample_ch.valid <= 1'b0;
                end
                else if (queued_samples.size() > 0)
                begin
                    next_sample = queued_samples.pop_front();
                    sample_ch.valid <= 1'b1;
                    sample_ch.raw_level <= next_sample.raw_level;
                    sample_ch.now_ms <= next_sample.now_ms;
                    sample_gap = pick_gap(sample_burst);
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        bdpc_pkg::result_t seen;
        bdpc_pkg::result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            result_stall = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                seen.press_event = result_ch.press_event;
                seen.level_edge = result_ch.level_edge;
                seen.is_pressed = result_ch.is_pressed;
                seen.press_duration_ms = result_ch.press_duration_ms;
                if (due_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result transfer with nothing outstanding: ev %0d edge %0d",
                                 $realtime, seen.press_event, seen.level_edge);
                end
                else
                begin
                    want = due_reports.pop_front();
                    reports_checked++;
                    if (seen !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: result %0d mismatch: ev %0d/%0d edge %0d/%0d",
                                     $realtime, reports_checked,
                                     want.press_event, seen.press_event,
                                     want.level_edge, seen.level_edge);
                            $display("    pressed %0b/%0b dur %0d/%0d (expected/actual)",
                                     want.is_pressed, seen.is_pressed,
                                     want.press_duration_ms, seen.press_duration_ms);
                        end
                    end
                end
                result_stall = pick_gap(result_burst);
                if ($urandom_range(0, 47) == 0)
                    result_burst = ~result_burst;
            end
            if (result_stall > 0)
            begin
                result_stall--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic push_sample(input logic raw, input logic [bdpc_pkg::TIME_W-1:0] now);
        bdpc_pkg::sample_t s;
        s.raw_level = raw;
        s.now_ms = now;
        queued_samples.push_back(s);
        stim_count++;
    endtask

    task automatic write_register(input logic [bdpc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [bdpc_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == bdpc_pkg::REG_LONG_PRESS)
            long_cfg_ms = val;
        else if (idx == bdpc_pkg::REG_DEBOUNCE)
            debounce_cfg_ms = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [bdpc_pkg::TIME_W-1:0] long_ms,
                                 input logic [bdpc_pkg::TIME_W-1:0] deb_ms);
        write_register(bdpc_pkg::REG_LONG_PRESS, long_ms);
        write_register(bdpc_pkg::REG_DEBOUNCE, deb_ms);
        settings_used++;
    endtask

    // wait until every sample went through and every result came back
    task automatic settle();
        while (queued_samples.size() != 0 || due_reports.size() != 0 || sample_ch.valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [bdpc_pkg::TIME_W-1:0] bounce_step();
        logic [bdpc_pkg::TIME_W-1:0] lim;
        if (debounce_cfg_ms <= 1)
            return $urandom_range(0, 2);
        lim = (debounce_cfg_ms - 1 > 40) ? 40 : debounce_cfg_ms - 1;
        return $urandom_range(0, lim);
    endfunction

    task automatic gen_presses(input int count);
        int target;
        int kind;
        int steps;
        logic [bdpc_pkg::TIME_W-1:0] t;
        logic [bdpc_pkg::TIME_W-1:0] base;
        logic [bdpc_pkg::TIME_W-1:0] hold;
        logic [bdpc_pkg::TIME_W-1:0] lim;
        target = stim_count + count;
        while (stim_count < target)
        begin
            kind = $urandom_range(0, 8);
            t = stim_ms;
            if (kind <= 6)
            begin
                repeat ($urandom_range(0, 3))
                begin
                    push_sample(1'b0, t);
                    t += bounce_step();
                    push_sample(1'b1, t);
                    t += bounce_step();
                end
                push_sample(1'b0, t);
                t += debounce_cfg_ms + $urandom_range(0, 2);
                push_sample(1'b0, t);
                case ($urandom_range(0, 3))
                    0:
                    begin
                        lim = (long_cfg_ms == 0) ? 0 :
                              (long_cfg_ms > 3000) ? 3000 : long_cfg_ms - 1;
                        hold = $urandom_range(0, lim);
                    end
                    1: hold = long_cfg_ms + $urandom_range(0, 2000);
                    2: hold = long_cfg_ms + $urandom_range(0, 2) - 1;
                    default: hold = $urandom_range(0, 100);
                endcase
                steps = $urandom_range(1, 5);
                base = t;
                for (int j = 1; j <= steps; j++)
                    push_sample(1'b0, base + 32'((64'(hold) * j) / steps));
                t = base + hold;
                repeat ($urandom_range(0, 3))
                begin
                    push_sample(1'b1, t);
                    t += bounce_step();
                    push_sample(1'b0, t);
                    t += bounce_step();
                end
                push_sample(1'b1, t);
                t += debounce_cfg_ms + $urandom_range(0, 2);
                push_sample(1'b1, t);
                repeat ($urandom_range(0, 3))
                begin
                    t += $urandom_range(1, 500);
                    push_sample(1'b1, t);
                end
            end
            else if (kind == 7)
            begin
                // glitch shorter than the debounce time when that exceeds one, then a jump back in time
                push_sample(1'b0, t);
                t += bounce_step();
                push_sample(1'b1, t);
                t -= $urandom_range(0, 1000);
                push_sample(1'b1, t);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    push_sample(1'($urandom_range(0, 1)), $urandom());
                t = $urandom();
            end
            stim_ms = t + $urandom_range(1, 200);
        end
    endtask

    initial
    begin
        sample_ch.valid = 1'b0;
        sample_ch.raw_level = 1'b1;
        sample_ch.now_ms = '0;
        result_ch.ready = 1'b0;
        long_cfg_ms = bdpc_pkg::LONG_PRESS_RESET;
        debounce_cfg_ms = bdpc_pkg::DEBOUNCE_RESET;
        line_last = 1'b1;
        line_change_ms = '0;
        line_stable = 1'b1;
        press_armed_q = 1'b0;
        long_fired = 1'b0;
        press_start_ms = '0;
        last_hold_ms = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: debounce threshold, long press, short press, wrap, extremes
        push_sample(1'b1, 32'd0);
        push_sample(1'b0, 32'd100);
        push_sample(1'b0, 32'd129);
        push_sample(1'b0, 32'd130);
        push_sample(1'b1, 32'd140);
        push_sample(1'b0, 32'd150);
        push_sample(1'b0, 32'd1129);
        push_sample(1'b0, 32'd1130);
        push_sample(1'b0, 32'd1500);
        push_sample(1'b1, 32'd1600);
        push_sample(1'b1, 32'd1630);
        push_sample(1'b0, 32'd2000);
        push_sample(1'b0, 32'd2030);
        push_sample(1'b1, 32'd2100);
        push_sample(1'b1, 32'd2130);
        push_sample(1'b1, 32'hFFFF_FFFF);
        push_sample(1'b0, 32'hFFFF_FFF0);
        push_sample(1'b0, 32'h0000_000E);
        push_sample(1'b1, 32'h0000_0020);
        push_sample(1'b1, 32'h0000_003E);
        stim_ms = 32'h0000_1000;
        gen_presses(300);
        settle();

        apply_setting(32'd1000, 32'd30);
        gen_presses(250);
        settle();

        // zero threshold: press edge and long event on the same sample
        apply_setting(32'd0, 32'd0);
        push_sample(1'b0, stim_ms);
        push_sample(1'b1, stim_ms + 32'd1);
        push_sample(1'b0, stim_ms + 32'd2);
        stim_ms += 32'd10;
        gen_presses(250);
        settle();

        apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_sample(1'b0, stim_ms);
        push_sample(1'b0, stim_ms - 32'd1);
        push_sample(1'b0, stim_ms - 32'd2);
        push_sample(1'b1, stim_ms + 32'd5);
        push_sample(1'b1, stim_ms + 32'd4);
        stim_ms += 32'd100;
        gen_presses(150);
        settle();

        apply_setting(32'd1, 32'd1);
        stim_ms = 32'hFFFF_F000;
        gen_presses(250);
        settle();

        apply_setting($urandom_range(20, 400), $urandom_range(0, 25));
        gen_presses(250);
        settle();

        apply_setting($urandom(), $urandom_range(0, 100));
        gen_presses(150);
        settle();

        apply_setting(32'd5000, 32'd0);
        gen_presses(200);
        settle();

        repeat (10) @(posedge clk);
        if (due_reports.size() != 0)
            $display("%0d results never arrived", due_reports.size());
        $display("covered %0d samples under %0d register settings, %0d results checked",
                 samples_sent, settings_used, reports_checked);
        $display("saw %0d pressed and %0d released edges, %0d short and %0d long presses",
                 press_edges, release_edges, short_events, long_events);
        if (mismatch_count == 0 && due_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("timeout with %0d samples queued and %0d results outstanding",
                 queued_samples.size(), due_reports.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
